### rtl/isf_pkg.sv
// Package for the inverse-square attractor force block.
// Holds the payload structs, the flag struct, the register index codes and fixed widths.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package isf_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DLT_W = 33;
  localparam int unsigned SQ_W = 66;
  localparam int unsigned LEN_W = 34;
  localparam int unsigned DEN_W = 102;
  localparam int unsigned QUO_W = 31;
  localparam int unsigned MIN_W = 31;

  typedef enum logic [1:0] {
    CFG_ATTR_X   = 2'd0,
    CFG_ATTR_Y   = 2'd1,
    CFG_STRENGTH = 2'd2,
    CFG_MIN_DIST = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] particle_x;
    logic signed [31:0] particle_y;
    logic               infinite_mass;
  } in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic               applied;
  } out_t;

  typedef struct packed {
    logic inf;
    logic zero;
    logic neg_x;
    logic neg_y;
  } flags_t;

endpackage

`default_nettype wire

### rtl/inverse_square_attractor_force.sv
// Top level of the inverse-square attractor force block.
// Depends on isf_pkg, isf_sqrt and isf_div.
//
// Usage: a particle transaction on the input channel (in_valid_i, in_ready_o, in_data_i)
// yields exactly one force transaction on the output channel (out_valid_o, out_ready_i,
// out_data_o), in order. The force points toward the attractor with magnitude
// strength / max(len, min_distance)^2 in signed fixed point with FRAC_BITS fraction bits,
// saturated to 32 bits. Immovable particles give zero force with applied low, and a
// particle on the attractor gives zero force with applied high.
// Registers are written through the cfg channel, which is always ready; write them only
// while no transaction is in flight.
// One transaction is taken every cycle while the receiver does not stall.
// The pipeline has 34 square root stages, 32 divider stages and 7 other stages.
// When the receiver stalls, the whole pipeline holds and in_ready_o falls.
// Reset empties the pipeline and restores the register defaults: attractor at the
// origin, strength 1.0 and minimum distance 1.0.
`timescale 1ns / 1ps
`default_nettype none

module inverse_square_attractor_force #(
  parameter int unsigned FRAC_BITS = isf_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire isf_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output isf_pkg::out_t      out_data_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [31:0]   cfg_data_i
);

  localparam int unsigned NUM_W = 65 + 2 * FRAC_BITS;
  localparam int unsigned SB_W = $bits(isf_pkg::flags_t) + 2 * NUM_W;
  localparam int unsigned LW = isf_pkg::LEN_W;

  logic [31:0]                  ax_q, ay_q, str_q;
  logic [isf_pkg::MIN_W-1:0]    min_q;
  logic                         adv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q  <= '0;
      ay_q  <= '0;
      str_q <= 32'd65536;
      min_q <= isf_pkg::MIN_W'(65536);
    end else if (cfg_valid_i) begin
      unique case (isf_pkg::cfg_idx_e'(cfg_index_i))
        isf_pkg::CFG_ATTR_X:   ax_q  <= cfg_data_i;
        isf_pkg::CFG_ATTR_Y:   ay_q  <= cfg_data_i;
        isf_pkg::CFG_STRENGTH: str_q <= cfg_data_i;
        isf_pkg::CFG_MIN_DIST: min_q <= cfg_data_i[isf_pkg::MIN_W-1:0];
        default:               ax_q  <= ax_q;
      endcase
    end
  end

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Offsets.
  logic                          a_vld_q, b_vld_q, c_vld_q;
  logic [isf_pkg::DLT_W-1:0]     dx_q, dy_q;
  logic                          inf_a_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q    <= {ax_q[31], ax_q} - {in_data_i.particle_x[31], in_data_i.particle_x};
      dy_q    <= {ay_q[31], ay_q} - {in_data_i.particle_y[31], in_data_i.particle_y};
      inf_a_q <= in_data_i.infinite_mass;
    end
  end

  // Squares and numerators.
  logic [isf_pkg::DLT_W-1:0]     adx, ady;
  logic [31:0]                   as;
  logic [isf_pkg::SQ_W-1:0]      sqx_q, sqy_q;
  logic [NUM_W-1:0]              nx_q, ny_q, nx_c_q, ny_c_q;
  isf_pkg::flags_t               fl_b_q, fl_c_q;

  always_comb begin
    adx = dx_q[isf_pkg::DLT_W-1] ? (~dx_q + isf_pkg::DLT_W'(1)) : dx_q;
    ady = dy_q[isf_pkg::DLT_W-1] ? (~dy_q + isf_pkg::DLT_W'(1)) : dy_q;
    as  = str_q[31] ? (~str_q + 32'd1) : str_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx_q        <= isf_pkg::SQ_W'(adx) * isf_pkg::SQ_W'(adx);
      sqy_q        <= isf_pkg::SQ_W'(ady) * isf_pkg::SQ_W'(ady);
      nx_q         <= {65'(as) * 65'(adx), {(2 * FRAC_BITS){1'b0}}};
      ny_q         <= {65'(as) * 65'(ady), {(2 * FRAC_BITS){1'b0}}};
      fl_b_q.inf   <= inf_a_q;
      fl_b_q.zero  <= (dx_q == '0) && (dy_q == '0);
      fl_b_q.neg_x <= str_q[31] ^ dx_q[isf_pkg::DLT_W-1];
      fl_b_q.neg_y <= str_q[31] ^ dy_q[isf_pkg::DLT_W-1];
    end
  end

  // Sum of squares.
  logic [isf_pkg::SQ_W-1:0]      sum_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q  <= sqx_q + sqy_q;
      nx_c_q <= nx_q;
      ny_c_q <= ny_q;
      fl_c_q <= fl_b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  logic                  r_vld;
  logic [LW-1:0]         len;
  logic [SB_W-1:0]       r_sb;

  isf_sqrt #(
    .SB_W (SB_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (c_vld_q),
    .sq_i    (sum_q),
    .sb_i    ({fl_c_q, nx_c_q, ny_c_q}),
    .valid_o (r_vld),
    .root_o  (len),
    .sb_o    (r_sb)
  );

  // Denominator D*D*L.
  logic                          e_vld_q, f_vld_q, g_vld_q;
  logic [LW-1:0]                 clamp_len;
  logic [2*LW-1:0]               p_q, pl_q, ph_q;
  logic [LW-1:0]                 len_e_q;
  logic [SB_W-1:0]               sb_e_q, sb_f_q, sb_g_q;
  logic [isf_pkg::DEN_W-1:0]     den_q;

  assign clamp_len = (len < LW'(min_q)) ? LW'(min_q) : len;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q     <= (2 * LW)'(clamp_len) * (2 * LW)'(clamp_len);
      len_e_q <= len;
      sb_e_q  <= r_sb;
      pl_q    <= (2 * LW)'(p_q[LW-1:0]) * (2 * LW)'(len_e_q);
      ph_q    <= (2 * LW)'(p_q[2*LW-1:LW]) * (2 * LW)'(len_e_q);
      sb_f_q  <= sb_e_q;
      den_q   <= isf_pkg::DEN_W'(pl_q) + isf_pkg::DEN_W'({ph_q, {LW{1'b0}}});
      sb_g_q  <= sb_f_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
    end else if (adv) begin
      e_vld_q <= r_vld;
      f_vld_q <= e_vld_q;
      g_vld_q <= f_vld_q;
    end
  end

  logic                          d_vld;
  logic [isf_pkg::QUO_W-1:0]     qx, qy;
  logic                          satx, saty;
  isf_pkg::flags_t               fl_d;

  isf_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (g_vld_q),
    .num_x_i (sb_g_q[2*NUM_W-1:NUM_W]),
    .num_y_i (sb_g_q[NUM_W-1:0]),
    .den_i   (den_q),
    .flags_i (isf_pkg::flags_t'(sb_g_q[SB_W-1:2*NUM_W])),
    .valid_o (d_vld),
    .quo_x_o (qx),
    .quo_y_o (qy),
    .sat_x_o (satx),
    .sat_y_o (saty),
    .flags_o (fl_d)
  );

  // Sign, saturation and special cases.
  logic                out_vld_q;
  isf_pkg::out_t       out_q;
  logic [31:0]         fx, fy;

  always_comb begin
    if (satx) begin
      fx = fl_d.neg_x ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      fx = fl_d.neg_x ? (~{1'b0, qx} + 32'd1) : {1'b0, qx};
    end
    if (saty) begin
      fy = fl_d.neg_y ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      fy = fl_d.neg_y ? (~{1'b0, qy} + 32'd1) : {1'b0, qy};
    end
    if (fl_d.inf || fl_d.zero) begin
      fx = '0;
      fy = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.force_x <= fx;
      out_q.force_y <= fy;
      out_q.applied <= !fl_d.inf;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/isf_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband payload.
// Depends on isf_pkg for the operand and root widths.
`timescale 1ns / 1ps
`default_nettype none

module isf_sqrt #(
  parameter int unsigned SB_W = 1
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire logic [isf_pkg::SQ_W-1:0]       sq_i,
  input  wire logic [SB_W-1:0]                sb_i,
  output logic                                valid_o,
  output logic [isf_pkg::LEN_W-1:0]           root_o,
  output logic [SB_W-1:0]                     sb_o
);

  localparam int unsigned NS = isf_pkg::LEN_W;
  localparam int unsigned SW = isf_pkg::SQ_W;
  localparam int unsigned TW = SW + 2;

  logic [SW-1:0]               rem_q  [NS];
  logic [isf_pkg::LEN_W-1:0]   root_q [NS];
  logic [SB_W-1:0]             sb_q   [NS];
  logic                        vld_q  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int unsigned B = NS - 1 - k;
    logic [SW-1:0]             rem_in;
    logic [isf_pkg::LEN_W-1:0] root_in;
    logic [SB_W-1:0]           sb_in;
    logic                      vld_in;
    logic [TW-1:0]             trial;
    logic                      take;

    if (k == 0) begin : g_first
      assign rem_in  = sq_i;
      assign root_in = '0;
      assign sb_in   = sb_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign sb_in   = sb_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    always_comb begin
      trial = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));
      take  = TW'(rem_in) >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? (rem_in - trial[SW-1:0]) : rem_in;
        root_q[k] <= take ? (root_in | (isf_pkg::LEN_W'(1) << B)) : root_in;
        sb_q[k]   <= sb_in;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = root_q[NS-1];
  assign sb_o    = sb_q[NS-1];

endmodule

`default_nettype wire

### rtl/isf_div.sv
// Pipelined restoring divider for the two force components sharing one denominator.
// First stage flags quotients of 2^31 or more; each later stage yields one quotient bit.
// Depends on isf_pkg for widths and the flag struct.
`timescale 1ns / 1ps
`default_nettype none

module isf_div #(
  parameter int unsigned NUM_W = 97
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire logic [NUM_W-1:0]               num_x_i,
  input  wire logic [NUM_W-1:0]               num_y_i,
  input  wire logic [isf_pkg::DEN_W-1:0]      den_i,
  input  wire isf_pkg::flags_t                flags_i,
  output logic                                valid_o,
  output logic [isf_pkg::QUO_W-1:0]           quo_x_o,
  output logic [isf_pkg::QUO_W-1:0]           quo_y_o,
  output logic                                sat_x_o,
  output logic                                sat_y_o,
  output isf_pkg::flags_t                     flags_o
);

  localparam int unsigned QW = isf_pkg::QUO_W;
  localparam int unsigned DW = (NUM_W > isf_pkg::DEN_W + QW + 1) ?
                               NUM_W : isf_pkg::DEN_W + QW + 1;
  localparam int unsigned NS = QW + 1;

  logic [DW-1:0]                 rx_q  [NS];
  logic [DW-1:0]                 ry_q  [NS];
  logic [isf_pkg::DEN_W-1:0]     den_q [NS];
  logic [QW-1:0]                 qx_q  [NS];
  logic [QW-1:0]                 qy_q  [NS];
  logic                          sx_q  [NS];
  logic                          sy_q  [NS];
  isf_pkg::flags_t               fl_q  [NS];
  logic [NS-1:0]                 vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q[0]  <= DW'(num_x_i);
      ry_q[0]  <= DW'(num_y_i);
      den_q[0] <= den_i;
      qx_q[0]  <= '0;
      qy_q[0]  <= '0;
      sx_q[0]  <= DW'(num_x_i) >= (DW'(den_i) << QW);
      sy_q[0]  <= DW'(num_y_i) >= (DW'(den_i) << QW);
      fl_q[0]  <= flags_i;
    end
  end

  for (genvar j = 1; j < NS; j++) begin : g_stage
    localparam int unsigned I = QW - j;
    logic [DW-1:0] dsh;
    logic          tx;
    logic          ty;

    always_comb begin
      dsh = DW'(den_q[j-1]) << I;
      tx  = rx_q[j-1] >= dsh;
      ty  = ry_q[j-1] >= dsh;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[j]  <= tx ? (rx_q[j-1] - dsh) : rx_q[j-1];
        ry_q[j]  <= ty ? (ry_q[j-1] - dsh) : ry_q[j-1];
        qx_q[j]  <= qx_q[j-1] | (QW'(tx) << I);
        qy_q[j]  <= qy_q[j-1] | (QW'(ty) << I);
        den_q[j] <= den_q[j-1];
        sx_q[j]  <= sx_q[j-1];
        sy_q[j]  <= sy_q[j-1];
        fl_q[j]  <= fl_q[j-1];
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quo_x_o = qx_q[NS-1];
  assign quo_y_o = qy_q[NS-1];
  assign sat_x_o = sx_q[NS-1];
  assign sat_y_o = sy_q[NS-1];
  assign flags_o = fl_q[NS-1];

endmodule

`default_nettype wire

### tb/tb_inverse_square_attractor_force.sv
// Testbench for the inverse-square attractor force block.
// Depends on isf_pkg and inverse_square_attractor_force.
// Directed and random particles under several settings, each checked by an exact predictor or a typed expected value.
`timescale 1ns / 1ps

module tb_inverse_square_attractor_force;

  localparam int unsigned FB = isf_pkg::FRAC_BITS_DEF;
  localparam int unsigned DRAIN = 100;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               inf;
    bit                 typed;
    isf_pkg::out_t      want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  isf_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  isf_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  isf_pkg::cfg_idx_e cfg_index = isf_pkg::CFG_ATTR_X;
  logic [31:0] cfg_data = '0;

  logic signed [31:0] attr_x = 0;
  logic signed [31:0] attr_y = 0;
  logic signed [31:0] strength = 65536;
  logic [30:0] min_dist = 65536;

  isf_pkg::out_t force_q[$];
  bit typed_q[$];
  isf_pkg::out_t typed_val_q[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  inverse_square_attractor_force dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [31:0] force_component(logic [31:0] mag_s, bit neg_s,
                                                  longint d, logic [127:0] den);
    logic [127:0] num;
    logic [127:0] q;
    logic [32:0] ad;
    bit neg;
    ad = (d < 0) ? 33'(-d) : 33'(d);
    num = (128'(mag_s) << (2 * FB)) * 128'(ad);
    q = num / den;
    neg = neg_s != (d < 0);
    if (neg) begin
      if (q >= 128'h8000_0000) return 32'h8000_0000;
      return 32'(-q);
    end
    if (q > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic isf_pkg::out_t attractor_force(isf_pkg::in_t p);
    isf_pkg::out_t r;
    longint dx;
    longint dy;
    logic [32:0] adx;
    logic [32:0] ady;
    logic [66:0] sq;
    logic [33:0] len;
    logic [33:0] t;
    logic [33:0] clamp;
    logic [127:0] den;
    logic [31:0] mag_s;
    r = '0;
    if (p.infinite_mass) return r;
    r.applied = 1'b1;
    dx = longint'(attr_x) - longint'(p.particle_x);
    dy = longint'(attr_y) - longint'(p.particle_y);
    adx = (dx < 0) ? 33'(-dx) : 33'(dx);
    ady = (dy < 0) ? 33'(-dy) : 33'(dy);
    sq = 67'(adx) * 67'(adx) + 67'(ady) * 67'(ady);
    if (sq == 0) return r;
    len = '0;
    for (int b = 33; b >= 0; b--) begin
      t = len | (34'd1 << b);
      if (68'(t) * 68'(t) <= 68'(sq)) len = t;
    end
    clamp = (len < 34'(min_dist)) ? 34'(min_dist) : len;
    den = 128'(clamp) * 128'(clamp) * 128'(len);
    mag_s = (strength < 0) ? 32'(-longint'(strength)) : strength;
    r.force_x = force_component(mag_s, strength < 0, dx, den);
    r.force_y = force_component(mag_s, strength < 0, dy, den);
    return r;
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    isf_pkg::out_t want;
    if (rst_n && in_valid && in_ready) begin
      want = attractor_force(in_data);
      if (typed_q.pop_front()) want = typed_val_q.pop_front();
      else void'(typed_val_q.pop_front());
      force_q.push_back(want);
    end
    if (rst_n && out_valid && out_ready) begin
      if (force_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected force transaction %p", out_data);
      end else begin
        want = force_q.pop_front();
        if (out_data !== want) begin
          errors++;
          if (errors <= 10)
            $display("Force mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  task automatic send_particle(row_t r);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    typed_q.push_back(r.typed);
    typed_val_q.push_back(r.want);
    in_valid <= 1'b1;
    in_data <= '{particle_x: r.px, particle_y: r.py, infinite_mass: r.inf};
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic write_reg(isf_pkg::cfg_idx_e idx, logic [31:0] val);
    in_valid <= 1'b0;
    while (force_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      isf_pkg::CFG_ATTR_X:   attr_x = val;
      isf_pkg::CFG_ATTR_Y:   attr_y = val;
      isf_pkg::CFG_STRENGTH: strength = val;
      default:               min_dist = val[30:0];
    endcase
  endtask

  function automatic logic [31:0] near(logic [31:0] base);
    case ($urandom_range(3))
      0:       return base + 32'($urandom_range(8)) - 32'd4;
      1:       return base + 32'($urandom_range(262144)) - 32'd131072;
      2:       return base + ($urandom() >>> $urandom_range(31));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    row_t dir[$];
    row_t r;
    logic [31:0] ax_set[7] = '{0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0010_0000,
                                 32'hFFF0_0000, 0, 32'h0003_8000};
    logic [31:0] ay_set[7] = '{0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFF8_0000,
                                 32'h0020_0000, 32'h0000_0001, 32'hFFFF_0000};
    logic [31:0] s_set[7] = '{65536, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                                32'hFFFE_0000, 32'h0000_0001, 32'h0140_0000};
    logic [31:0] m_set[7] = '{65536, 0, 32'h7FFF_FFFF, 32'h0000_0001,
                                32'h0004_0000, 0, 32'h0000_8000};
    int idle_set[4] = '{0, 57, 0, 36};
    int stall_set[4] = '{0, 0, 57, 36};

    dir.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 1'b1, '{0, 0, 1'b0}});
    dir.push_back('{0, 0, 1'b1, 1'b1, '{0, 0, 1'b0}});
    dir.push_back('{0, 0, 1'b0, 1'b1, '{0, 0, 1'b1}});
    dir.push_back('{-65536, 0, 1'b0, 1'b1, '{65536, 0, 1'b1}});
    dir.push_back('{0, -65536, 1'b0, 1'b1, '{0, 65536, 1'b1}});
    dir.push_back('{65536, 0, 1'b0, 1'b1, '{-65536, 0, 1'b1}});
    dir.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b0, '0});
    dir.push_back('{32'sh8000_0000, 32'sh8000_0000, 1'b0, 1'b0, '0});
    dir.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b0, '0});
    dir.push_back('{32'sh8000_0000, 0, 1'b0, 1'b0, '0});
    dir.push_back('{1, 0, 1'b0, 1'b0, '0});
    dir.push_back('{0, -1, 1'b0, 1'b0, '0});
    dir.push_back('{-1, -1, 1'b0, 1'b0, '0});
    dir.push_back('{32768, -32768, 1'b0, 1'b0, '0});
    dir.push_back('{-300000, 200000, 1'b0, 1'b0, '0});
    dir.push_back('{-1, 32'sh8000_0000, 1'b0, 1'b0, '0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir[i]) send_particle(dir[i]);

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(isf_pkg::CFG_ATTR_X, ax_set[ph]);
      write_reg(isf_pkg::CFG_ATTR_Y, ay_set[ph]);
      write_reg(isf_pkg::CFG_STRENGTH, s_set[ph]);
      write_reg(isf_pkg::CFG_MIN_DIST, m_set[ph]);
      for (int k = 0; k < 250; k++) begin
        idle_pct = idle_set[(ph + k / 63) % 4];
        stall_pct = stall_set[(ph + k / 63) % 4];
        r.px = near(attr_x);
        r.py = near(attr_y);
        r.inf = ($urandom_range(9) == 0);
        r.typed = 1'b0;
        r.want = '0;
        send_particle(r);
      end
    end
    in_valid <= 1'b0;
    stall_pct = 0;
    while (force_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && force_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
